/* rtl/core/bsmd_pkg.sv */
// Shared types and constants for the bisection subdivision matrix decoder.
// No dependencies.
package bsmd_pkg;

	localparam int unsigned IdW  = 25;  // heap id width
	localparam int unsigned OutW = 25;  // output entry width
	localparam int unsigned CntW = 5;   // holds 0..IdW-1 applied splits

	// Control that travels with an item from cell to cell
	typedef struct packed {
		logic            vld;
		logic            started;  // leading one already seen
		logic [CntW-1:0] cnt;      // splits applied so far
	} bsmd_ctl_t;

endpackage

/* rtl/core/bsmd_cell.sv */
// One cell of the decode chain: looks at one heap id bit and applies at most one split.
// Depends on bsmd_pkg.
module bsmd_cell #(
	parameter int unsigned W     = 25,  // entry width, MAX_DEPTH + 1
	parameter int unsigned BIT   = 24,  // heap id bit this cell examines
	parameter int unsigned LIMIT = 24   // most splits an item may take
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  bsmd_pkg::bsmd_ctl_t             up_ctl,
	input  logic [bsmd_pkg::IdW-1:0]        up_id,
	input  logic [8:0][W-1:0]               up_mat,
	output bsmd_pkg::bsmd_ctl_t             dn_ctl,
	output logic [bsmd_pkg::IdW-1:0]        dn_id,
	output logic [8:0][W-1:0]               dn_mat
);

	bsmd_pkg::bsmd_ctl_t          ctl_q, ctl_d;
	logic [bsmd_pkg::IdW-1:0]     id_q;
	logic [8:0][W-1:0]            mat_q, mat_d, split;
	logic                         b;
	logic                         apply;

	assign b = up_id[BIT];
	assign apply = up_ctl.started &&
		(up_ctl.cnt < bsmd_pkg::CntW'(LIMIT));

	// S(b) premultiply, column by column
	always_comb begin
		logic [W-1:0] half1;
		for (int j = 0; j < 3; j++) begin
			half1 = up_mat[3 + j] >> 1;
			split[j]     = half1 + (b ? up_mat[6 + j] : '0);
			split[3 + j] = b ? up_mat[j] : up_mat[6 + j];
			split[6 + j] = (b ? '0 : up_mat[j]) + half1;
		end
	end

	always_comb begin
		ctl_d = up_ctl;
		mat_d = up_mat;
		if (apply) begin
			mat_d     = split;
			ctl_d.cnt = up_ctl.cnt + 1'b1;
		end else if (!up_ctl.started && b) begin
			ctl_d.started = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_q  <= up_id;
			mat_q <= mat_d;
		end
	end

	assign dn_ctl = ctl_q;
	assign dn_id  = id_q;
	assign dn_mat = mat_q;

endmodule

/* rtl/core/bisection_subdivision_matrix_decode_top.sv */
// Top level of the bisection subdivision matrix decoder.
// Depends on bsmd_pkg and bsmd_cell.

// Decodes a bisection heap id into its 3x3 subdivision matrix, entries in
// fixed point with MAX_DEPTH fraction bits. A chain of 25 cells, one per heap
// id bit from the top down, carries each item; a cell splits the matrix once
// the leading one has passed, up to MAX_DEPTH splits but never more than
// IdW-1. out_valid rises once an item has passed all 25 cell registers,
// and one item is taken every cycle unless the output stalls. The last
// cell is the output register; while its result waits the whole chain holds.
module bisection_subdivision_matrix_decode_top #(
	parameter int unsigned MAX_DEPTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bsmd_pkg::IdW-1:0]       heap_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bsmd_pkg::OutW-1:0]      m00,
	output logic [bsmd_pkg::OutW-1:0]      m01,
	output logic [bsmd_pkg::OutW-1:0]      m02,
	output logic [bsmd_pkg::OutW-1:0]      m10,
	output logic [bsmd_pkg::OutW-1:0]      m11,
	output logic [bsmd_pkg::OutW-1:0]      m12,
	output logic [bsmd_pkg::OutW-1:0]      m20,
	output logic [bsmd_pkg::OutW-1:0]      m21,
	output logic [bsmd_pkg::OutW-1:0]      m22
);

	localparam int unsigned W     = MAX_DEPTH + 1;
	localparam int unsigned NCELL = bsmd_pkg::IdW;
	localparam int unsigned LIMIT = (MAX_DEPTH > NCELL - 1) ? NCELL - 1 : MAX_DEPTH;

	bsmd_pkg::bsmd_ctl_t          ctl [NCELL+1];
	logic [bsmd_pkg::IdW-1:0]     id  [NCELL+1];
	logic [8:0][W-1:0]            mat [NCELL+1];
	logic [bsmd_pkg::OutW-1:0]    res [9];
	logic                         en;

	assign en       = !ctl[NCELL].vld || out_ready;
	assign in_ready = en;

	always_comb begin
		ctl[0].vld     = in_valid;
		ctl[0].started = 1'b0;
		ctl[0].cnt     = '0;
		id[0]          = heap_id;
		for (int k = 0; k < 9; k++) begin
			mat[0][k] = '0;
		end
		mat[0][0] = {1'b1, {MAX_DEPTH{1'b0}}};
		mat[0][4] = {1'b1, {MAX_DEPTH{1'b0}}};
		mat[0][8] = {1'b1, {MAX_DEPTH{1'b0}}};
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		bsmd_cell #(
			.W     (W),
			.BIT   (NCELL - 1 - g),
			.LIMIT (LIMIT)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up_ctl (ctl[g]),
			.up_id  (id[g]),
			.up_mat (mat[g]),
			.dn_ctl (ctl[g+1]),
			.dn_id  (id[g+1]),
			.dn_mat (mat[g+1])
		);
	end

	// zero-extend or keep the low output bits of each entry
	always_comb begin
		logic [bsmd_pkg::OutW+W-1:0] ext;
		for (int k = 0; k < 9; k++) begin
			ext    = {{bsmd_pkg::OutW{1'b0}}, mat[NCELL][k]};
			res[k] = ext[bsmd_pkg::OutW-1:0];
		end
	end

	assign out_valid = ctl[NCELL].vld;
	assign m00 = res[0];
	assign m01 = res[1];
	assign m02 = res[2];
	assign m10 = res[3];
	assign m11 = res[4];
	assign m12 = res[5];
	assign m20 = res[6];
	assign m21 = res[7];
	assign m22 = res[8];

endmodule
